// File: hw/rtl/lrg_pkg.sv
// Shared types, constants and the cell rule for the row-streaming life generation block.
package lrg_pkg;

  // Fixed row payload width and default number of cells built
  localparam int ROW_BITS      = 64;
  localparam int WIDTH_BITS    = 7;
  localparam int MAX_WIDTH_DEF = 64;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 7'd64;

  // B3/S23 neighbor counts
  localparam logic [3:0] BIRTH_CNT   = 4'd3;
  localparam logic [3:0] SURVIVE_CNT = 4'd2;

  // Result queue depth and its count width
  localparam int QDEPTH = 3;
  localparam int QCNT_BITS = 2;

  // Per-beat control handed to every cell
  typedef struct packed {
    logic held;   // a row above the incoming one is kept
    logic load;   // beat accepted this cycle
  } cell_ctrl_t;

  // Bits a cell shows to its two neighbors, already masked to the row width
  typedef struct packed {
    logic up;     // kept upper row
    logic mid;    // kept middle row
    logic row;    // incoming row
    logic nup;    // upper row as seen by the bottom-row flush
  } cell_nb_t;

  // One result beat
  typedef struct packed {
    logic [ROW_BITS-1:0] cells;
    logic                last;
  } res_t;

  // Next state of one cell from its own state and live neighbor count
  function automatic logic life_next(input logic alive, input logic [3:0] cnt);
    return (cnt == BIRTH_CNT) || (alive && (cnt == SURVIVE_CNT));
  endfunction

endpackage

// File: hw/rtl/lrg_if.sv
// Row input and result output channel interfaces.
interface lrg_row_in_if;
  logic                          valid;
  logic                          ready;
  logic [lrg_pkg::ROW_BITS-1:0]  row_cells;
  logic                          first_row;
  logic                          last_row;

  modport source (output valid, output row_cells, output first_row, output last_row,
                  input ready);
  modport sink (input valid, input row_cells, input first_row, input last_row,
                output ready);
endinterface

interface lrg_row_out_if;
  logic                          valid;
  logic                          ready;
  logic [lrg_pkg::ROW_BITS-1:0]  next_cells;
  logic                          last_of_grid;

  modport source (output valid, output next_cells, output last_of_grid, input ready);
  modport sink (input valid, input next_cells, input last_of_grid, output ready);
endinterface

// File: hw/rtl/life_row_generation_step.sv
// Top level: one B3/S23 generation over a grid streamed in one row per beat.
// A result beat is offered in the cycle after its row beat when the queue is empty.
// Throughput: one row per cycle while the result queue has room; a bottom row yields
//   two results, and the three-entry queue then holds input off with the output ready.
// Reset (synchronous, rst_n low): no rows kept, result queue empty,
//   row_width 64. Kept row bits are not cleared; they are unused until loaded.
module life_row_generation_step #(
  parameter int MAX_WIDTH = lrg_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lrg_row_in_if.sink                      in_row,
  lrg_row_out_if.source                   out_row,
  input  logic                            cfg_we,
  input  logic [lrg_pkg::WIDTH_BITS-1:0]  cfg_wdata
);
  import lrg_pkg::*;

  logic [WIDTH_BITS-1:0] width_r;
  logic                  held_r, held_nxt;
  logic [MAX_WIDTH-1:0]  en;
  logic [MAX_WIDTH-1:0]  a_bits, b_bits;
  cell_nb_t              nb [MAX_WIDTH];
  cell_ctrl_t            ctrl;
  logic                  accept, in_ready;
  logic                  has_a, has_b;
  logic [1:0]            npush;
  res_t                  res_a, res_b, push0, push1, head;
  logic                  out_valid;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
    end else if (cfg_we) begin
      width_r <= cfg_wdata;
    end
  end

  // Column enables; a width of zero still keeps cell 0
  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      en[i] = (i == 0) || (width_r > WIDTH_BITS'(i));
    end
  end

  assign accept = in_row.valid & in_ready;
  assign in_row.ready = in_ready;

  // A top mark drops the kept rows
  assign ctrl.held = held_r & ~in_row.first_row;
  assign ctrl.load = accept;

  assign held_nxt = accept ? ~in_row.last_row : held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
    end
  end

  // Cell row, each column talking to its two neighbors
  for (genvar g = 0; g < MAX_WIDTH; g++) begin : g_cell
    cell_nb_t nb_lo, nb_hi;
    if (g == 0) begin : g_lo_edge
      assign nb_lo = '0;
    end else begin : g_lo
      assign nb_lo = nb[g-1];
    end
    if (g == MAX_WIDTH - 1) begin : g_hi_edge
      assign nb_hi = '0;
    end else begin : g_hi
      assign nb_hi = nb[g+1];
    end
    lrg_cell u_cell (
      .clk     (clk),
      .en      (en[g]),
      .row_bit (in_row.row_cells[g]),
      .ctrl    (ctrl),
      .nb_lo   (nb_lo),
      .nb_hi   (nb_hi),
      .nb_own  (nb[g]),
      .a_bit   (a_bits[g]),
      .b_bit   (b_bits[g])
    );
  end

  // Results of this beat, row above first
  assign has_a = accept & ctrl.held;
  assign has_b = accept & in_row.last_row;
  assign npush = {1'b0, has_a} + {1'b0, has_b};

  assign res_a.cells = ROW_BITS'(a_bits);
  assign res_a.last  = 1'b0;
  assign res_b.cells = ROW_BITS'(b_bits);
  assign res_b.last  = 1'b1;
  assign push0 = has_a ? res_a : res_b;
  assign push1 = res_b;

  lrg_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .npush     (npush),
    .push0     (push0),
    .push1     (push1),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_row.ready),
    .head      (head)
  );

  assign out_row.valid        = out_valid;
  assign out_row.next_cells   = head.cells;
  assign out_row.last_of_grid = head.last;

  // Bottom row always yields a result beat next cycle
  a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_row.last_row |=> out_valid)
    else $error("bottom row gave no result");

  // Inner rows with a kept row above yield a result
  a_inner_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ctrl.held |=> out_valid)
    else $error("inner row gave no result");

  // Input is only held off while results are queued
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result queue");

endmodule

// File: hw/rtl/lrg_cell.sv
// One column cell: holds the kept upper and middle bits and computes both result bits.
module lrg_cell (
  input  logic               clk,
  input  logic               en,
  input  logic               row_bit,
  input  lrg_pkg::cell_ctrl_t ctrl,
  input  lrg_pkg::cell_nb_t  nb_lo,
  input  lrg_pkg::cell_nb_t  nb_hi,
  output lrg_pkg::cell_nb_t  nb_own,
  output logic               a_bit,
  output logic               b_bit
);
  import lrg_pkg::*;

  logic       up_r, mid_r;
  logic [3:0] cnt_a, cnt_b;

  // Masked view shared with neighbors
  assign nb_own.up  = en & up_r;
  assign nb_own.mid = en & mid_r;
  assign nb_own.row = en & row_bit;
  assign nb_own.nup = en & ctrl.held & mid_r;

  // Neighbor counts for the row above the incoming one and for the flushed bottom row
  assign cnt_a = 4'(nb_lo.up) + 4'(nb_own.up) + 4'(nb_hi.up)
               + 4'(nb_lo.mid) + 4'(nb_hi.mid)
               + 4'(nb_lo.row) + 4'(nb_own.row) + 4'(nb_hi.row);
  assign cnt_b = 4'(nb_lo.nup) + 4'(nb_own.nup) + 4'(nb_hi.nup)
               + 4'(nb_lo.row) + 4'(nb_hi.row);

  assign a_bit = en & life_next(nb_own.mid, cnt_a);
  assign b_bit = en & life_next(nb_own.row, cnt_b);

  // Shift kept rows down one on every accepted beat
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      up_r  <= nb_own.nup;
      mid_r <= nb_own.row;
    end
  end

endmodule

// File: hw/rtl/lrg_out_queue.sv
// Three-entry shifting result queue between the cell row and the output channel.
module lrg_out_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     npush,
  input  lrg_pkg::res_t  push0,
  input  lrg_pkg::res_t  push1,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output lrg_pkg::res_t  head
);
  import lrg_pkg::*;

  res_t                 q_r   [QDEPTH];
  res_t                 q_nxt [QDEPTH];
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [QCNT_BITS-1:0] lvl;
  logic                 pop;

  assign out_valid = (cnt_r != '0);
  assign head      = q_r[0];
  assign pop       = out_valid & out_ready;
  assign lvl       = cnt_r - QCNT_BITS'(pop);
  // Room for two results keeps the input side free of any path from the output
  assign room      = (cnt_r <= QCNT_BITS'(1));
  assign cnt_nxt   = lvl + npush;

  // Shift on pop, then append the new results behind what is left
  always_comb begin
    int j;
    for (int k = 0; k < QDEPTH; k++) begin
      j = (k + 1 < QDEPTH) ? k + 1 : k;
      q_nxt[k] = pop ? q_r[j] : q_r[k];
      if ((npush != 2'd0) && (k == int'(lvl))) begin
        q_nxt[k] = push0;
      end
      if ((npush == 2'd2) && (k == int'(lvl) + 1)) begin
        q_nxt[k] = push1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QDEPTH; k++) begin
      q_r[k] <= q_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: verif/life_row_generation_step_tb.sv
`timescale 1ns / 1ps
// Testbench for life_row_generation_step: directed and random grids checked against a predictor.
module life_row_generation_step_tb;
  import lrg_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ROWS    = 500;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [WIDTH_BITS-1:0] cfg_wdata;

  lrg_row_in_if  in_if ();
  lrg_row_out_if out_if ();

  life_row_generation_step i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_row    (in_if),
    .out_row   (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: kept rows and the active width
  logic [ROW_BITS-1:0]   kept_upper  = '0;
  logic [ROW_BITS-1:0]   kept_middle = '0;
  int                    kept_count  = 0;
  logic [WIDTH_BITS-1:0] cur_width   = WIDTH_RESET;
  res_t                  pending_rows[$];

  int error_count   = 0;
  int rows_sent     = 0;
  int results_seen  = 0;
  int idle_cycles   = 0;
  int width_writes  = 0;
  int random_grids  = 0;
  int burst_left    = 0;

  // Receiver stall pattern state
  int stall_left  = 0;
  int stall_mode  = 0;
  int mode_cycles = 0;

  // Width 0 acts as 1, anything past the row acts as the full row
  function automatic logic [ROW_BITS-1:0] width_mask_of(input logic [WIDTH_BITS-1:0] w);
    int n;
    n = (w == 0) ? 1 : int'(w);
    if (n >= ROW_BITS) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // B3/S23 successor of mid; everything outside the mask is dead
  function automatic logic [ROW_BITS-1:0] life_successor(input logic [ROW_BITS-1:0] up,
                                                         input logic [ROW_BITS-1:0] mid,
                                                         input logic [ROW_BITS-1:0] dn,
                                                         input logic [ROW_BITS-1:0] mask);
    logic [ROW_BITS-1:0] a, b, c, nxt;
    int cnt;
    a = up & mask;
    b = mid & mask;
    c = dn & mask;
    nxt = '0;
    for (int i = 0; i < ROW_BITS; i++) begin
      cnt = int'(a[i]) + int'(c[i]);
      if (i > 0) cnt += int'(a[i-1]) + int'(b[i-1]) + int'(c[i-1]);
      if (i < ROW_BITS - 1) cnt += int'(a[i+1]) + int'(b[i+1]) + int'(c[i+1]);
      nxt[i] = (cnt == BIRTH_CNT) || (b[i] && (cnt == SURVIVE_CNT));
    end
    return nxt & mask;
  endfunction

  // Advance the predictor by one accepted row and queue its results
  task automatic predict_generation(input logic [ROW_BITS-1:0] cells, input logic first,
                                    input logic last);
    logic [ROW_BITS-1:0] mask, row;
    res_t r;
    mask = width_mask_of(cur_width);
    row  = cells & mask;
    if (first) begin
      kept_upper  = '0;
      kept_middle = '0;
      kept_count  = 0;
    end
    if (kept_count >= 1) begin
      r.cells = life_successor(kept_upper, kept_middle, row, mask);
      r.last  = 1'b0;
      pending_rows.insert(pending_rows.size(), r);
      kept_upper = kept_middle & mask;
    end else begin
      kept_upper = '0;
    end
    kept_middle = row;
    if (kept_count < 2) kept_count++;
    if (last) begin
      r.cells = life_successor(kept_upper, kept_middle, '0, mask);
      r.last  = 1'b1;
      pending_rows.insert(pending_rows.size(), r);
      kept_upper  = '0;
      kept_middle = '0;
      kept_count  = 0;
    end
  endtask

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endtask

  // Monitor: check result beats, track config writes, predict from row beats, watchdog
  always @(posedge clk) begin : monitor
    res_t want;
    if (rst_n) begin
      idle_cycles++;
      if (out_if.valid && out_if.ready) begin
        idle_cycles = 0;
        results_seen++;
        if (pending_rows.size() == 0) begin
          report_error($sformatf("result with nothing pending: next_cells %h last %b",
                                 out_if.next_cells, out_if.last_of_grid));
        end else begin
          want = pending_rows.pop_front();
          if (out_if.next_cells !== want.cells || out_if.last_of_grid !== want.last)
            report_error($sformatf("next_cells exp %h got %h, last_of_grid exp %b got %b",
                                   want.cells, out_if.next_cells, want.last,
                                   out_if.last_of_grid));
        end
      end
      if (cfg_we) begin
        idle_cycles = 0;
        cur_width = cfg_wdata;
      end
      if (in_if.valid && in_if.ready) begin
        idle_cycles = 0;
        predict_generation(in_if.row_cells, in_if.first_row, in_if.last_row);
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Receiver: mode changes now and then between no stalls, short and long stalls
  always @(posedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode  = $urandom_range(0, 2);
      mode_cycles = $urandom_range(40, 120);
    end
    mode_cycles--;
    if (stall_left == 0) begin
      if (stall_mode == 1 && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
      if (stall_mode == 2 && $urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 7);
    end
    if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Send one row beat; the sender runs in bursts with random gaps in between
  task automatic send_row(input logic [ROW_BITS-1:0] cells, input logic first,
                          input logic last);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(30, 60);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 8);
        gap = $urandom_range(0, 5);
      end
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid     <= 1'b1;
    in_if.row_cells <= cells;
    in_if.first_row <= first;
    in_if.last_row  <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
    rows_sent++;
  endtask

  // Hold input off until every queued result has come, then let the pipe settle
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_width(input logic [WIDTH_BITS-1:0] w);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_writes++;
  endtask

  // Both marks on one row, with full and patterned rows at reset width
  task automatic test_single_row_grids();
    send_row('1, 1'b1, 1'b1);
    send_row('0, 1'b1, 1'b1);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1);
    send_row(64'h5555_5555_5555_5555, 1'b1, 1'b1);
  endtask

  // Vertical blinker at column 10, horizontal pieces on both row edges
  task automatic test_blinkers();
    send_row(64'h400, 1'b1, 1'b0);
    send_row(64'h400, 1'b0, 1'b0);
    send_row(64'h400, 1'b0, 1'b1);
    send_row('0, 1'b1, 1'b0);
    send_row(64'hE000_0000_0000_0007, 1'b0, 1'b0);
    send_row('0, 1'b0, 1'b1);
  endtask

  // Grid started without a top mark right after a bottom row
  task automatic test_missing_top_mark();
    send_row('1, 1'b0, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b0, 1'b1);
  endtask

  // A second top mark drops the kept rows without results
  task automatic test_top_mark_mid_grid();
    send_row({$urandom, $urandom}, 1'b1, 1'b0);
    send_row({$urandom, $urandom}, 1'b0, 1'b0);
    send_row('1, 1'b1, 1'b0);
    send_row('1, 1'b0, 1'b1);
  endtask

  // Width 0, width past the row, and a width change with rows kept
  task automatic test_width_extremes();
    write_width(7'd0);
    send_row('1, 1'b1, 1'b1);
    write_width(7'd127);
    send_row('1, 1'b1, 1'b0);
    send_row('1, 1'b0, 1'b1);
    write_width(7'd5);
    send_row(64'h1F, 1'b1, 1'b0);
    send_row(64'hFF, 1'b0, 1'b0);
    write_width(7'd3);
    send_row('1, 1'b0, 1'b1);
  endtask

  // One random grid: mostly well formed, some with missing or extra marks
  task automatic send_random_grid();
    int height, fill, kind, pick;
    logic [ROW_BITS-1:0] cells;
    logic first, last;
    pick = $urandom_range(0, 9);
    if (pick == 0) height = 1;
    else if (pick == 1) height = $urandom_range(9, 20);
    else height = $urandom_range(2, 8);
    fill = $urandom_range(0, 4);
    kind = $urandom_range(0, 9);
    for (int r = 0; r < height; r++) begin
      case (fill)
        0: cells = {$urandom, $urandom};
        1: cells = {$urandom, $urandom} & {$urandom, $urandom};
        2: cells = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        3: cells = {$urandom, $urandom} | {$urandom, $urandom};
        default: cells = ~({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
      endcase
      first = (r == 0) && (kind != 0);
      if (kind == 1 && r > 0 && r == height / 2) first = 1'b1;
      last = (r == height - 1) && (kind != 2);
      send_row(cells, first, last);
    end
  endtask

  // Random grids, with a new width every few grids and an occasional full drain
  task automatic test_random_grids();
    int start;
    logic [WIDTH_BITS-1:0] w;
    start = rows_sent;
    while (rows_sent - start < RANDOM_ROWS) begin
      if (random_grids % 4 == 0) begin
        case ($urandom_range(0, 7))
          0: w = 7'd0;
          1: w = 7'd1;
          2: w = 7'd2;
          3: w = 7'd3;
          4: w = 7'd64;
          5: w = 7'd127;
          default: w = WIDTH_BITS'($urandom_range(0, 127));
        endcase
        write_width(w);
      end else if ($urandom_range(0, 9) == 0) begin
        wait_for_results();
      end
      send_random_grid();
      random_grids++;
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_if.valid     <= 1'b0;
    in_if.row_cells <= '0;
    in_if.first_row <= 1'b0;
    in_if.last_row  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_row_grids();
    test_blinkers();
    test_missing_top_mark();
    test_top_mark_mid_grid();
    test_width_extremes();
    test_random_grids();

    wait_for_results();
    repeat (5) @(posedge clk);
    if (pending_rows.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_rows.size()));

    $display("Sent %0d rows (%0d random grids) over %0d width settings.",
             rows_sent, random_grids, width_writes);
    $display("Checked %0d result rows, %0d mismatches.", results_seen, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/lrg_pkg.sv
hw/rtl/lrg_if.sv
hw/rtl/lrg_cell.sv
hw/rtl/lrg_out_queue.sv
hw/rtl/life_row_generation_step.sv
verif/life_row_generation_step_tb.sv
